[rtl/ddtc_pkg.sv]
// Package for the drift-diffusion trial counter: fixed-point widths,
// register indexes, configuration and result types.
// Used by every module of the block but ddtc_checker; depends on nothing.
`timescale 1ns / 1ps

package ddtc_pkg;

	localparam int FRAC_BITS = 12;

	localparam int SAMPLE_W = 16;
	localparam int EV_W     = 24;
	localparam int EL_W     = 17;
	localparam int CNT_W    = 16;
	localparam int TSTEP_W  = 10;

	// noise_sd (unsigned 16) times sample (signed 16), plus one guard bit for rounding
	localparam int PROD_W = SAMPLE_W + 17;
	localparam int RND_W  = PROD_W + 1;
	localparam int INC_W  = RND_W - FRAC_BITS;
	localparam int SUM_W  = ((EV_W > INC_W) ? EV_W : INC_W) + 2;

	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 3;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DRIFT       = 3'd0,
		REG_NOISE_SD    = 3'd1,
		REG_NONDEC      = 3'd2,
		REG_MAX_DUR     = 3'd3,
		REG_MIN_DUR     = 3'd4,
		REG_EXP_CHOICE  = 3'd5,
		REG_TIME_STEP   = 3'd6,
		REG_RUN_COUNT   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0]  drift_per_step;
		logic [15:0]         noise_sd;
		logic [15:0]         nondecision_time;
		logic [15:0]         max_duration;
		logic [15:0]         min_duration;
		logic                expected_choice;
		logic [TSTEP_W-1:0]  time_step;
		logic [CNT_W-1:0]    run_count;
	} cfg_t;

	typedef struct packed {
		logic              last;
		logic [CNT_W-1:0]  success_total;
		logic              run_success;
		logic [15:0]       run_time;
		logic              choice;
		logic              decided;
	} result_t;

endpackage

[rtl/ddtc_regs.sv]
// Configuration register file with an APB-style access port.
// Depends on ddtc_pkg for the register indexes and cfg_t.
`timescale 1ns / 1ps

module ddtc_regs
	import ddtc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drift_per_step   <= '0;
			cfg_q.noise_sd         <= '0;
			cfg_q.nondecision_time <= '0;
			cfg_q.max_duration     <= '0;
			cfg_q.min_duration     <= '0;
			cfg_q.expected_choice  <= 1'b0;
			cfg_q.time_step        <= TSTEP_W'(1);
			cfg_q.run_count        <= CNT_W'(1);
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				REG_DRIFT:      cfg_q.drift_per_step   <= $signed(pwdata[15:0]);
				REG_NOISE_SD:   cfg_q.noise_sd         <= pwdata[15:0];
				REG_NONDEC:     cfg_q.nondecision_time <= pwdata[15:0];
				REG_MAX_DUR:    cfg_q.max_duration     <= pwdata[15:0];
				REG_MIN_DUR:    cfg_q.min_duration     <= pwdata[15:0];
				REG_EXP_CHOICE: cfg_q.expected_choice  <= pwdata[0];
				REG_TIME_STEP:  cfg_q.time_step        <= pwdata[TSTEP_W-1:0];
				REG_RUN_COUNT:  cfg_q.run_count        <= pwdata[CNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DRIFT:      prdata = APB_DW'(unsigned'(cfg_q.drift_per_step));
			REG_NOISE_SD:   prdata = APB_DW'(cfg_q.noise_sd);
			REG_NONDEC:     prdata = APB_DW'(cfg_q.nondecision_time);
			REG_MAX_DUR:    prdata = APB_DW'(cfg_q.max_duration);
			REG_MIN_DUR:    prdata = APB_DW'(cfg_q.min_duration);
			REG_EXP_CHOICE: prdata = APB_DW'(cfg_q.expected_choice);
			REG_TIME_STEP:  prdata = APB_DW'(cfg_q.time_step);
			REG_RUN_COUNT:  prdata = APB_DW'(cfg_q.run_count);
		endcase
	end

endmodule

[rtl/ddtc_scale.sv]
// Input register and noise scaling stage: noise_sd * sample, rounded to
// FRAC_BITS fraction bits (ties toward plus infinity). Depends on ddtc_pkg.
`timescale 1ns / 1ps

module ddtc_scale
	import ddtc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [15:0]                noise_sd,
	input  logic                       accum_ready,
	output logic                       inc_valid,
	output logic signed [INC_W-1:0]    inc
);

	localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (FRAC_BITS - 1);

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       valid_s2;
	logic signed [INC_W-1:0]    inc_s2;
	logic                       ready_s2;
	logic signed [PROD_W-1:0]   prod;
	logic signed [RND_W-1:0]    rnd;

	assign ready_s2 = !valid_s2 || accum_ready;
	assign s_tready = !valid_s1 || ready_s2;

	assign prod = $signed({1'b0, noise_sd}) * sample_s1;
	assign rnd  = RND_W'(prod) + HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			sample_s1 <= sample;
		// arithmetic right shift of the rounded product is floor division
		if (ready_s2 && valid_s1)
			inc_s2 <= rnd[RND_W-1:FRAC_BITS];
	end

	assign inc_valid = valid_s2;
	assign inc       = inc_s2;

endmodule

[rtl/ddtc_accum.sv]
// Evidence accumulator, run and batch bookkeeping, and the result register.
// Depends on ddtc_pkg for cfg_t, result_t and the fixed-point widths.
`timescale 1ns / 1ps

module ddtc_accum
	import ddtc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    inc_valid,
	input  logic signed [INC_W-1:0] inc,
	output logic                    accum_ready,
	output logic                    res_valid,
	input  logic                    res_ready,
	output result_t                 res
);

	localparam logic signed [SUM_W-1:0] EV_MAX  = (SUM_W'(1) <<< (EV_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] EV_MIN  = -(SUM_W'(1) <<< (EV_W - 1));
	localparam logic signed [EV_W-1:0]  ONE     = EV_W'(1) <<< FRAC_BITS;
	localparam logic signed [EV_W-1:0]  NEG_ONE = -ONE;

	logic signed [EV_W-1:0]  evidence_q;
	logic [EL_W-1:0]         elapsed_q;
	logic [CNT_W-1:0]        successes_q;
	logic [CNT_W-1:0]        runs_done_q;
	logic                    res_valid_q;
	result_t                 res_q;

	logic signed [SUM_W-1:0] ev_sum;
	logic signed [EV_W-1:0]  ev_sat;
	logic [EL_W:0]           el_sum;
	logic [EL_W-1:0]         el_new;
	logic [EL_W:0]           tot_time;
	logic                    timed_out;
	logic                    decided;
	logic                    choice;
	logic                    success;
	logic                    has_res;
	logic                    last;
	logic [CNT_W-1:0]        total;
	logic                    out_free;
	logic                    fire;
	result_t                 res_d;

	assign timed_out = elapsed_q >= EL_W'(cfg.max_duration);

	always_comb begin
		ev_sum = SUM_W'(evidence_q) + SUM_W'(cfg.drift_per_step) + SUM_W'(inc);
		if (ev_sum > EV_MAX)
			ev_sat = EV_W'(EV_MAX);
		else if (ev_sum < EV_MIN)
			ev_sat = EV_W'(EV_MIN);
		else
			ev_sat = ev_sum[EV_W-1:0];

		el_sum = {1'b0, elapsed_q} + (EL_W + 1)'(cfg.time_step);
		// a sample that arrives after the timeout leaves the time alone
		if (timed_out)
			el_new = elapsed_q;
		else if (el_sum[EL_W])
			el_new = '1;
		else
			el_new = el_sum[EL_W-1:0];

		decided  = !timed_out && (ev_sat >= ONE || ev_sat <= NEG_ONE);
		has_res  = timed_out || decided || (el_new >= EL_W'(cfg.max_duration));
		choice   = decided && ev_sat[EV_W-1];
		tot_time = {1'b0, el_new} + (EL_W + 1)'(cfg.nondecision_time);
		success  = decided && (choice == cfg.expected_choice)
			&& (tot_time <= (EL_W + 1)'(cfg.max_duration))
			&& (tot_time >= (EL_W + 1)'(cfg.min_duration));
		total    = successes_q + CNT_W'(success);
		last     = ({1'b0, runs_done_q} + (CNT_W + 1)'(1)) >= {1'b0, cfg.run_count};

		res_d.decided       = decided;
		res_d.choice        = choice;
		res_d.run_time      = (el_new > EL_W'(16'hFFFF)) ? 16'hFFFF : el_new[15:0];
		res_d.run_success   = success;
		res_d.success_total = total;
		res_d.last          = last;
	end

	// items that end no run pass even while a result is stalled
	assign out_free    = !res_valid_q || res_ready;
	assign accum_ready = !has_res || out_free;
	assign fire        = inc_valid && accum_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evidence_q  <= '0;
			elapsed_q   <= '0;
			successes_q <= '0;
			runs_done_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire && has_res)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;

			if (fire) begin
				if (has_res) begin
					evidence_q <= '0;
					elapsed_q  <= '0;
					if (last) begin
						successes_q <= '0;
						runs_done_q <= '0;
					end else begin
						successes_q <= total;
						runs_done_q <= runs_done_q + CNT_W'(1);
					end
				end else begin
					evidence_q <= ev_sat;
					elapsed_q  <= el_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_res)
			res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/drift_diffusion_trial_counter_unit.sv]
// Top level of the drift-diffusion trial counter: APB register file,
// scaling stage and accumulator. Depends on ddtc_pkg and the ddtc_* modules.
//
// The block takes one noise sample per clock cycle on its input stream,
// while s_tready is high, and emits one result transaction at the end of
// each simulated run. A sample passes an input register, a stage with the
// noise_sd multiplier and rounding, and the accumulate stage, whose
// evidence and time update is combinational; the result of a run is
// registered in the output register when the accumulate stage accepts the
// sample that ended the run. Samples that end no run keep flowing while a
// result waits in the output register; the pipeline stalls only when a run
// end reaches the accumulate stage while a result still waits, and then at
// most one more sample is accepted behind it. Register writes over APB
// complete without wait states and must be made while no sample is in flight.
`timescale 1ns / 1ps

module drift_diffusion_trial_counter_unit
	import ddtc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready,
	// samples in
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] noise_sample
	// results out
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [0] decided, [1] choice, [17:2] run_time,
	                                         // [18] run_success, [34:19] success_total,
	                                         // [39:35] zero
	output logic                  m_tlast
);

	cfg_t                    cfg;
	logic                    accum_ready;
	logic                    inc_valid;
	logic signed [INC_W-1:0] inc;
	result_t                 res;

	ddtc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ddtc_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.sample      ($signed(s_tdata[SAMPLE_W-1:0])),
		.noise_sd    (cfg.noise_sd),
		.accum_ready (accum_ready),
		.inc_valid   (inc_valid),
		.inc         (inc)
	);

	ddtc_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.inc_valid   (inc_valid),
		.inc         (inc),
		.accum_ready (accum_ready),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res         (res)
	);

	assign m_tdata = {5'b0, res.success_total, res.run_success, res.run_time,
		res.choice, res.decided};
	assign m_tlast = res.last;

endmodule

[rtl/ddtc_checker.sv]
// Port-level checks for the drift-diffusion trial counter, bound to the top.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module ddtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// a timeout reports the upper-bound choice and no success
	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> !m_tdata[1] && !m_tdata[18])
		else $error("timeout with choice or success set");

	// the running total includes this run's success
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[18] |-> m_tdata[34:19] != 16'd0)
		else $error("success with zero total");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:35] == 5'd0 && pready)
		else $error("padding bits set or pready low");

endmodule

bind drift_diffusion_trial_counter_unit ddtc_checker u_ddtc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
